### hw/rtl/b64enc_pkg.sv
// shared types, constants and the alphabet lookup for the base64 stream encoder
package b64enc_pkg;

	// queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// pad counts carried with a group
	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ONE  = 2'd1;
	localparam logic [1:0] PAD_TWO  = 2'd2;

	// character positions within a group
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_FOURTH = 2'd3;

	// pending byte counts in the front
	localparam logic [1:0] CNT_EMPTY = 2'd0;
	localparam logic [1:0] CNT_ONE   = 2'd1;
	localparam logic [1:0] CNT_TWO   = 2'd2;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] UPPER_BASE = 8'h41;
	localparam logic [7:0] LOWER_BASE = 8'h61;
	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;

	// one complete or padded group of up to three bytes
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  npad;
		logic        last;
	} group_t;

	// sextet to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] six);
		logic [7:0] v;
		logic [7:0] c;
		v = {2'b00, six};
		if (six < 6'd26) begin
			c = 8'(UPPER_BASE + v);
		end else if (six < 6'd52) begin
			c = 8'(LOWER_BASE + v - 8'd26);
		end else if (six < 6'd62) begin
			c = 8'(DIGIT_BASE + v - 8'd52);
		end else if (six == 6'd62) begin
			c = PLUS_CHAR;
		end else begin
			c = SLASH_CHAR;
		end
		return c;
	endfunction

endpackage

### hw/rtl/b64enc_front.sv
// front: collects input bytes and forms groups for the queue
module b64enc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            in_byte,
	input  logic                  last_byte,
	input  logic                  q_full,
	output logic                  q_push,
	output b64enc_pkg::group_t    q_data
);
	import b64enc_pkg::*;

	logic [1:0]  pending_count_q;
	logic [15:0] pending_bytes_q;
	logic        accept;

	// hold off the sender while the queue has no room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// group formation
	always_comb begin
		q_push = 1'b0;
		q_data = '0;
		if (accept) begin
			if (pending_count_q == CNT_TWO) begin
				q_push = 1'b1;
				q_data.bits = {pending_bytes_q, in_byte};
				q_data.npad = PAD_NONE;
				q_data.last = last_byte;
			end else if (last_byte) begin
				q_push = 1'b1;
				q_data.last = 1'b1;
				if (pending_count_q == CNT_EMPTY) begin
					q_data.bits = {in_byte, 16'h0000};
					q_data.npad = PAD_TWO;
				end else begin
					q_data.bits = {pending_bytes_q[15:8], in_byte, 8'h00};
					q_data.npad = PAD_ONE;
				end
			end
		end
	end

	// pending byte state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_count_q <= CNT_EMPTY;
			pending_bytes_q <= '0;
		end else if (accept) begin
			if (q_push) begin
				pending_count_q <= CNT_EMPTY;
				pending_bytes_q <= '0;
			end else if (pending_count_q == CNT_EMPTY) begin
				pending_count_q <= CNT_ONE;
				pending_bytes_q <= {in_byte, 8'h00};
			end else begin
				pending_count_q <= CNT_TWO;
				pending_bytes_q <= {pending_bytes_q[15:8], in_byte};
			end
		end
	end

	// never more than two bytes held
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_count_q != 2'd3)
		else $error("front holds more than two bytes");

endmodule

### hw/rtl/b64enc_queue.sv
// short group queue between front and back
module b64enc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64enc_pkg::group_t    push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output b64enc_pkg::group_t    head_data
);
	import b64enc_pkg::*;

	group_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// no write into a full queue, no read from an empty one
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("queue underflow");

endmodule

### hw/rtl/b64enc_back.sv
// back: turns queued groups into four output characters, one per beat
module b64enc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  b64enc_pkg::group_t    head_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_char,
	output logic                  group_end,
	output logic                  message_end
);
	import b64enc_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       group_end_q;
	logic       message_end_q;
	logic       load;
	logic [5:0] sextet;
	logic       is_pad;
	logic [7:0] next_char;

	// output register free or draining this cycle
	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop  = load && (idx_q == POS_FOURTH);

	// sextet selection and padding
	always_comb begin
		case (idx_q)
			POS_FIRST:  sextet = head_data.bits[23:18];
			POS_SECOND: sextet = head_data.bits[17:12];
			POS_THIRD:  sextet = head_data.bits[11:6];
			POS_FOURTH: sextet = head_data.bits[5:0];
			default:    sextet = '0;
		endcase
		is_pad = ((idx_q == POS_FOURTH) && (head_data.npad != PAD_NONE))
			|| ((idx_q == POS_THIRD) && (head_data.npad == PAD_TWO));
		next_char = is_pad ? PAD_CHAR : enc_char(sextet);
	end

	// character position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= POS_FIRST;
		end else if (load) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q    <= next_char;
			group_end_q   <= (idx_q == POS_FOURTH);
			message_end_q <= (idx_q == POS_FOURTH) && head_data.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign group_end   = group_end_q;
	assign message_end = message_end_q;

	// message end only on the closing character of a group
	a_msg_on_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!message_end_q || group_end_q))
		else $error("message end without group end");

	// a group end beat leaves the position counter at the first character
	a_group_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(load && idx_q == POS_FOURTH) |=> (idx_q == POS_FIRST && group_end_q))
		else $error("group position did not wrap");

endmodule

### hw/rtl/base64_stream_encoder.sv
// top level of the base64 stream encoder: front, group queue and back
// path: the byte that closes a group is written into the group queue, and the first character of
//   that group is then loaded into the output register once the back is free
// throughput: one byte per cycle into the front while in_stall is low, one character per cycle out
//   of the back while a group is queued and out_stall is low; each group gives four characters
// the two-entry group queue lets the front keep taking bytes while the back drains a group
// reset: arst_n clears pending bytes, queue pointers, character position and output valid
module base64_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       group_end,
	output logic       message_end
);
	import b64enc_pkg::*;

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	logic   q_head_valid;
	group_t q_push_data;
	group_t q_head_data;

	// byte collection
	b64enc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_push_data)
	);

	// group queue
	b64enc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head_data)
	);

	// character emission
	b64enc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_head_valid),
		.head_data   (q_head_data),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.group_end   (group_end),
		.message_end (message_end)
	);

endmodule

### tb/testbench.sv
// self-checking testbench for the base64 stream encoder
`timescale 1ns / 1ps

module testbench;
	import b64enc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_BYTES = 160;
	localparam int unsigned CALM_BYTES   = 24;

	// one expected output character
	typedef struct {
		logic [7:0] ch;
		logic       grp_end;
		logic       msg_end;
	} b64_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       group_end;
	logic       message_end;

	// encoder state as the predictor sees it
	logic [1:0] held_count = 2'd0;
	logic [7:0] held_first = 8'h00;
	logic [7:0] held_second = 8'h00;

	b64_char_t   chars_due[$];
	string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	int unsigned chars_seen = 0;
	int unsigned stall_left = 0;
	bit          gaps_on = 1'b1;

	base64_stream_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.group_end   (group_end),
		.message_end (message_end)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still due", cycle_count,
				chars_due.size());
			$display("** base64_stream_encoder: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("%0t: char %0d: %s got %h expected %h", $time, chars_seen, what, got, want);
		err_count++;
	endtask

	// queue the four characters of a group of one to three real bytes
	task automatic emit_group(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
		input int nreal, input logic msg);
		b64_char_t c;
		logic [5:0] six [4];
		six[0] = b0[7:2];
		six[1] = {b0[1:0], b1[7:4]};
		six[2] = {b1[3:0], b2[7:6]};
		six[3] = b2[5:0];
		for (int k = 0; k < 4; k++) begin
			c.ch = (k > nreal) ? PAD_CHAR : alphabet[six[k]];
			c.grp_end = (k == 3);
			c.msg_end = (k == 3) && msg;
			chars_due.push_back(c);
		end
	endtask

	// advance the predictor by one accepted byte
	task automatic predict_byte(input logic [7:0] b, input logic last);
		if (held_count == 2'd2) begin
			emit_group(held_first, held_second, b, 3, last);
			held_count = 2'd0;
			held_first = 8'h00;
			held_second = 8'h00;
		end else begin
			if (held_count == 2'd0) begin
				held_first = b;
			end else begin
				held_second = b;
			end
			held_count = held_count + 2'd1;
			if (last) begin
				// padded group: unused bits of the held bytes are zero
				emit_group(held_first, (held_count == 2'd2) ? held_second : 8'h00, 8'h00,
					int'(held_count), 1'b1);
				held_count = 2'd0;
				held_first = 8'h00;
				held_second = 8'h00;
			end
		end
	endtask

	// drive one byte beat and wait for it to be taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		in_valid <= 1'b1;
		in_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		predict_byte(b, last);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1) begin
				out_stall <= 1'b0;
			end
		end else if (gaps_on && arst_n && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(1, 5);
		end
	end

	// compare each character beat with the oldest expectation
	always @(posedge clk) begin
		b64_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			chars_seen++;
			if (chars_due.size() == 0) begin
				report_mismatch("unexpected out_char", out_char, 8'h00);
			end else begin
				want = chars_due.pop_front();
				if (out_char !== want.ch) begin
					report_mismatch("out_char", out_char, want.ch);
				end
				if (group_end !== want.grp_end) begin
					report_mismatch("group_end", {7'd0, group_end}, {7'd0, want.grp_end});
				end
				if (message_end !== want.msg_end) begin
					report_mismatch("message_end", {7'd0, message_end}, {7'd0, want.msg_end});
				end
			end
		end
	end

	// one byte per message: two characters and double padding
	task automatic test_single_byte;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b1);
	endtask

	// two bytes per message: three characters and single padding
	task automatic test_two_bytes;
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b1);
	endtask

	// message ends with a full group, no padding
	task automatic test_full_group_end;
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	// full group followed by a padded tail
	task automatic test_group_then_tail;
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b0);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b1);
		send_byte(8'h03, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h3F, 1'b0);
		send_byte(8'hC0, 1'b1);
	endtask

	// random messages, idling switched on and off per message
	task automatic test_random_messages;
		int unsigned sent;
		int len;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
			gaps_on = ($urandom_range(0, 4) != 0);
			send_message(len);
			sent += len;
		end
	endtask

	// back to back with neither side idling
	task automatic test_full_rate;
		int unsigned sent;
		int len;
		gaps_on = 1'b0;
		sent = 0;
		while (sent < CALM_BYTES) begin
			len = $urandom_range(1, 8);
			send_message(len);
			sent += len;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_byte();
		test_two_bytes();
		test_full_group_end();
		test_group_then_tail();
		test_random_messages();
		test_full_rate();

		in_valid <= 1'b0;
		while (chars_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0) begin
			$display("** base64_stream_encoder: PASSED **");
		end else begin
			$display("** base64_stream_encoder: FAILED **");
		end
		$finish;
	end

endmodule

### base64_stream_encoder.f
hw/rtl/b64enc_pkg.sv
hw/rtl/b64enc_front.sv
hw/rtl/b64enc_queue.sv
hw/rtl/b64enc_back.sv
hw/rtl/base64_stream_encoder.sv
tb/testbench.sv
